// ===== design/ptt_pkg.sv =====
// Shared types, codes and helpers of the periodic task timer table.
package ptt_pkg;

    // Default table depth
    localparam int SLOTS_DEF = 32;

    // Action codes of a command word
    localparam logic [2:0] A_REGISTER = 3'd0;
    localparam logic [2:0] A_REMOVE   = 3'd1;
    localparam logic [2:0] A_CHANGE   = 3'd2;
    localparam logic [2:0] A_EXISTS   = 3'd3;
    localparam logic [2:0] A_TICK     = 3'd4;

    // Result kinds
    localparam logic [2:0] K_FIRED     = 3'd0;
    localparam logic [2:0] K_TICK_DONE = 3'd1;
    localparam logic [2:0] K_COUNT     = 3'd2;
    localparam logic [2:0] K_EXISTS    = 3'd3;
    localparam logic [2:0] K_REG_STAT  = 3'd4;

    // Mode flag bit positions
    localparam int M_REPEAT = 0;
    localparam int M_LOOP   = 1;
    localparam int M_START  = 2;
    localparam int M_END    = 3;

    // One second in time units, and the loop mode codes
    localparam logic [34:0] ONE_SEC   = 35'd256;
    localparam logic [1:0]  LOOP_CNT  = 2'b01;
    localparam logic [1:0]  LOOP_NONE = 2'b00;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_REG,
        S_SCAN,
        S_DONE
    } t_state;

    // Command word
    typedef struct packed {
        logic [2:0]         action;
        logic [7:0]         owner;
        logic [15:0]        handler;
        logic signed [31:0] task_id;
        logic [31:0]        period;
        logic [3:0]         mode_flags;
        logic [14:0]        repeat_count;
        logic [31:0]        now;
        logic [15:0]        time_limit;
        logic [31:0]        time_base;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic [2:0]         kind;
        logic [4:0]         slot;
        logic [15:0]        fired_handler;
        logic signed [31:0] fired_id;
        logic [5:0]         count;
        logic               flag;
        logic               last;
    } t_out_word;

    // One table entry as stored in the slot memory
    typedef struct packed {
        logic [7:0]         owner;
        logic [15:0]        handler;
        logic signed [31:0] task_id;
        logic [31:0]        period;
        logic [31:0]        next_time;
        logic [15:0]        repeats;
        logic [3:0]         mode;
    } t_entry;

    // Per-slot update decision
    typedef struct packed {
        logic   wr;     // write entry back
        logic   clr;    // free the slot
        logic   hit;    // counts toward the summary
        logic   fire;   // report a fired task
        t_entry entry;
    } t_eval;

    // Unsigned add that sticks at all ones
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

// ===== design/periodic_task_timer_table.sv =====
// Top level of the periodic task timer table: controller, slot memory and scan.
//
// A command word is taken when start is high and busy is low. Every command first
// passes through a precompute state for its time terms. Register then walks the
// used bits from slot 0 and stores into the first free slot, or reports a full
// table. Remove, change, exists and tick read the slot memory one entry per cycle
// and write back changed entries; that pass over the single-read, single-write
// slot memory sets the rate. Unknown actions give nothing and return to idle after
// the precompute state. Results come on o_rsp for one cycle each, marked by
// o_strobe, and cannot be held off: a tick gives at most one fired word per cycle
// during its scan and then its summary word. The final word of a command carries
// last.
module periodic_task_timer_table import ptt_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_word  i_cmd,
    output logic      busy,
    output logic      o_strobe,
    output t_out_word o_rsp
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
    localparam int ENTRY_W = $bits(t_entry);

    t_state           r_state, n_state;
    t_in_word         r_cmd;
    logic [31:0]      r_now_plus, n_now_plus;
    logic [34:0]      r_start_val, n_start_val;
    logic [34:0]      r_end_val, n_end_val;
    logic [IDX_W-1:0] r_addr, n_addr;
    logic [IDX_W-1:0] r_wb_idx, n_wb_idx;
    logic             r_issuing, n_issuing;
    logic             r_pend, n_pend;
    logic [CNT_W-1:0] r_n, n_n;
    logic [SLOTS-1:0] r_used, n_used;
    logic             r_strobe, n_strobe;
    t_out_word        r_rsp, n_rsp;

    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr;
    t_entry           ram_wdata, ram_rdata;
    t_eval            ev;

    logic [CNT_W+5:0] n_ext;
    logic [5:0]       count_sat;
    logic [IDX_W+4:0] addr_ext, wb_ext;
    logic [24:0]      tlim_sec;
    t_entry           new_entry;

    assign busy     = r_state != S_IDLE;
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

    // Summary count and slot field formatting
    assign n_ext     = {6'b0, r_n};
    assign count_sat = (n_ext > (CNT_W + 6)'(63)) ? 6'd63 : n_ext[5:0];
    assign addr_ext  = {5'b0, r_addr};
    assign wb_ext    = {5'b0, r_wb_idx};

    // Round limit in seconds: minutes*60
    assign tlim_sec = {3'b000, r_cmd.time_limit, 6'b0} - {7'b0, r_cmd.time_limit, 2'b0};

    // Entry stored by register
    always_comb begin
        new_entry           = '0;
        new_entry.owner     = r_cmd.owner;
        new_entry.handler   = r_cmd.handler;
        new_entry.task_id   = r_cmd.task_id;
        new_entry.period    = r_cmd.period;
        new_entry.next_time = r_now_plus;
        new_entry.mode      = r_cmd.mode_flags;
        new_entry.repeats   = (r_cmd.mode_flags[M_LOOP:M_REPEAT] == LOOP_CNT)
                              ? {1'b0, r_cmd.repeat_count} : 16'd0;
    end

    // Slot memory
    ptt_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(SLOTS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(r_addr),
        .o_rdata(ram_rdata)
    );

    // Evaluation of the entry read in the previous cycle
    ptt_slot_eval u_eval (
        .i_used     (r_used[r_wb_idx]),
        .i_entry    (ram_rdata),
        .i_cmd      (r_cmd),
        .i_now_plus (r_now_plus),
        .i_start_val(r_start_val),
        .i_end_val  (r_end_val),
        .o_eval     (ev)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (r_cmd.action == A_REGISTER) begin
                    n_state = S_REG;
                end else if (r_cmd.action inside {A_REMOVE, A_CHANGE, A_EXISTS, A_TICK}) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_REG: begin
                if (!r_used[r_addr] || (r_addr == LAST_IDX)) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (r_pend && !r_issuing) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath and output controls
    always_comb begin
        n_now_plus  = r_now_plus;
        n_start_val = r_start_val;
        n_end_val   = r_end_val;
        n_addr      = r_addr;
        n_wb_idx    = r_wb_idx;
        n_issuing   = r_issuing;
        n_pend      = 1'b0;
        n_n         = r_n;
        n_used      = r_used;
        n_strobe    = 1'b0;
        n_rsp       = '0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = r_wb_idx;
        ram_wdata   = ev.entry;
        case (r_state)
            S_PREP: begin
                n_now_plus  = sat_add(r_cmd.now, r_cmd.period);
                n_start_val = {3'b000, r_cmd.now} - {3'b000, r_cmd.time_base} + ONE_SEC;
                n_end_val   = {3'b000, r_cmd.time_base} + {10'b0, tlim_sec}
                              - {3'b000, r_cmd.now} - ONE_SEC;
                n_addr      = '0;
                n_issuing   = 1'b1;
                n_n         = '0;
            end
            S_REG: begin
                if (!r_used[r_addr]) begin
                    ram_we         = 1'b1;
                    ram_waddr      = r_addr;
                    ram_wdata      = new_entry;
                    n_used[r_addr] = 1'b1;
                    n_strobe       = 1'b1;
                    n_rsp.kind     = K_REG_STAT;
                    n_rsp.slot     = addr_ext[4:0];
                    n_rsp.last     = 1'b1;
                end else if (r_addr == LAST_IDX) begin
                    n_strobe   = 1'b1;
                    n_rsp.kind = K_REG_STAT;
                    n_rsp.flag = 1'b1;
                    n_rsp.last = 1'b1;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_SCAN: begin
                // issue side
                if (r_issuing) begin
                    ram_re   = 1'b1;
                    n_pend   = 1'b1;
                    n_wb_idx = r_addr;
                    if (r_addr == LAST_IDX) begin
                        n_issuing = 1'b0;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end
                // write-back side
                if (r_pend) begin
                    ram_we = ev.wr;
                    if (ev.clr) begin
                        n_used[r_wb_idx] = 1'b0;
                    end
                    if (ev.hit) begin
                        n_n = r_n + 1'b1;
                    end
                    if (ev.fire) begin
                        n_strobe            = 1'b1;
                        n_rsp.kind          = K_FIRED;
                        n_rsp.slot          = wb_ext[4:0];
                        n_rsp.fired_handler = ram_rdata.handler;
                        n_rsp.fired_id      = ram_rdata.task_id;
                    end
                end
            end
            S_DONE: begin
                n_strobe   = 1'b1;
                n_rsp.last = 1'b1;
                if (r_cmd.action == A_EXISTS) begin
                    n_rsp.kind = K_EXISTS;
                    n_rsp.flag = r_n != '0;
                end else if (r_cmd.action == A_TICK) begin
                    n_rsp.kind  = K_TICK_DONE;
                    n_rsp.count = count_sat;
                end else begin
                    n_rsp.kind  = K_COUNT;
                    n_rsp.count = count_sat;
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    // Registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_strobe  <= 1'b0;
            r_issuing <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_strobe  <= n_strobe;
            r_issuing <= n_issuing;
            r_pend    <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && start) begin
            r_cmd <= i_cmd;
        end
        r_now_plus  <= n_now_plus;
        r_start_val <= n_start_val;
        r_end_val   <= n_end_val;
        r_addr      <= n_addr;
        r_wb_idx    <= n_wb_idx;
        r_n         <= n_n;
        r_rsp       <= n_rsp;
    end

endmodule

// ===== design/ptt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/ptt_slot_eval.sv =====
// Per-slot match, due test and entry update for one scanned table entry.
module ptt_slot_eval import ptt_pkg::*; (
    input  logic        i_used,
    input  t_entry      i_entry,
    input  t_in_word    i_cmd,
    input  logic [31:0] i_now_plus,
    input  logic [34:0] i_start_val,
    input  logic [34:0] i_end_val,
    output t_eval       o_eval
);

    logic        match;
    logic        due;
    logic        loop;
    logic        counting;
    logic [34:0] period_ext;
    logic [15:0] reps_dec;
    t_entry      upd;

    assign period_ext = {3'b000, i_entry.period};
    assign match      = i_used && (i_entry.task_id == i_cmd.task_id)
                        && (i_entry.owner == i_cmd.owner);
    assign loop       = i_entry.mode[M_LOOP:M_REPEAT] != LOOP_NONE;
    assign counting   = i_entry.mode[M_LOOP:M_REPEAT] == LOOP_CNT;
    assign reps_dec   = i_entry.repeats - 16'd1;

    // Due test, first mode that applies wins
    always_comb begin
        if (i_entry.mode[M_START]) begin
            due = $signed(i_start_val) >= $signed(period_ext);
        end else if (i_entry.mode[M_END]) begin
            due = (i_cmd.time_limit != 16'd0) && ($signed(i_end_val) <= $signed(period_ext));
        end else begin
            due = i_entry.next_time <= i_cmd.now;
        end
    end

    // Update decision by action
    always_comb begin
        upd    = i_entry;
        o_eval = '0;
        case (i_cmd.action)
            A_REMOVE: begin
                o_eval.hit = match;
                o_eval.clr = match;
            end
            A_CHANGE: begin
                upd.period    = i_cmd.period;
                upd.next_time = i_now_plus;
                o_eval.hit    = match;
                o_eval.wr     = match;
            end
            A_EXISTS: begin
                o_eval.hit = match;
            end
            A_TICK: begin
                if (i_used && due) begin
                    upd.next_time = sat_add(i_entry.next_time, i_entry.period);
                    if (counting && (i_entry.repeats == 16'd0)) begin
                        // exhausted counter: dropped silently
                        o_eval.clr = 1'b1;
                    end else begin
                        o_eval.fire = 1'b1;
                        o_eval.hit  = 1'b1;
                        if (!loop) begin
                            o_eval.clr = 1'b1;
                        end else if (counting) begin
                            upd.repeats = reps_dec;
                            if (reps_dec == 16'd0) begin
                                o_eval.clr = 1'b1;
                            end else begin
                                o_eval.wr = 1'b1;
                            end
                        end else begin
                            o_eval.wr = 1'b1;
                        end
                    end
                end
            end
            default: begin
                o_eval.hit = 1'b0;
            end
        endcase
        o_eval.entry = upd;
    end

endmodule

// ===== design/ptt_checker.sv =====
// Port-level checks of the periodic task timer table, bound to the top level.
module ptt_checker import ptt_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_strobe,
    input t_out_word o_rsp
);

    // A taken command always raises busy in the cycle after it is taken
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after a command was taken");

    // The final word of a command leaves the block idle
    a_idle_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_rsp.last |-> !busy)
        else $error("block still busy on a final result");

    // No word other than a final one shows while idle
    a_no_stray_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !busy |-> o_rsp.last)
        else $error("non-final result while idle");

    // Fired words are never final; summary and status words always are
    a_fired_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_rsp.kind == K_FIRED) |-> !o_rsp.last)
        else $error("fired word marked last");

    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && ((o_rsp.kind == K_TICK_DONE) || (o_rsp.kind == K_COUNT)
                     || (o_rsp.kind == K_EXISTS) || (o_rsp.kind == K_REG_STAT))
        |-> o_rsp.last)
        else $error("summary word not marked last");

endmodule

bind periodic_task_timer_table ptt_checker u_ptt_checker (.*);
